### rtl/lsf_pkg.sv
// Shared types, sizes and helper functions for the recently seen ID filter.
// Used by the cell, encoder and top-level modules; depends on nothing else.
package lsf_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int ID_BITS     = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 9;
  localparam int MSG_W       = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_ENCODE,
    ST_UPDATE
  } lsf_state_t;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] limit;
    logic [CNT_W-1:0] fill;
  } cell_ctl_t;

  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] res;
    if (int'(cap) > MAX_ENTRIES) begin
      res = CNT_W'(MAX_ENTRIES);
    end else if (cap == '0) begin
      res = CNT_W'(1);
    end else begin
      res = CNT_W'(cap);
    end
    return res;
  endfunction

  function automatic logic [MAX_ENTRIES-1:0] bit_mask(input int b);
    logic [MAX_ENTRIES-1:0] m;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      m[i] = ((i >> b) & 1) == 1;
    end
    return m;
  endfunction

endpackage

### rtl/lru_seen_id_filter.sv
// Each accepted request registers its key, then steps through MATCH (cells compare), ENCODE
// (hit index registered) and UPDATE (chain shifts, result registered); UPDATE stalls while an
// unread result is held. One request at a time; the next request is taken while a result waits.
// Reset empties the store at once (fill count zero) and sets capacity to 256.
// No clearing pass is needed. Depends on lsf_pkg, lsf_cell and lsf_encode.
module lru_seen_id_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lsf_pkg::MSG_W-1:0]     msg_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          first_seen,
  input  logic                          cfg_wr_en,
  input  logic [lsf_pkg::CAP_W-1:0]     cfg_wr_data
);

  lsf_pkg::lsf_state_t                  state, state_next;
  logic [lsf_pkg::CAP_W-1:0]            capacity;
  logic [lsf_pkg::CNT_W-1:0]            fill, fill_next, fill_upd;
  logic [lsf_pkg::CNT_W-1:0]            cap, new_cap;
  logic [lsf_pkg::ID_BITS-1:0]          key;
  logic [lsf_pkg::ID_BITS-1:0]          ids [lsf_pkg::MAX_ENTRIES];
  logic [lsf_pkg::MAX_ENTRIES-1:0]      match_vec;
  logic                                 hit;
  logic [lsf_pkg::IDX_W-1:0]            hit_idx;
  logic                                 accept, update;
  logic                                 full;
  lsf_pkg::cell_ctl_t                   ctl;

  assign cap     = lsf_pkg::eff_cap(capacity);
  assign new_cap = lsf_pkg::eff_cap(cfg_wr_data);
  assign full    = fill >= cap;
  assign accept  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    update     = 1'b0;
    unique case (state)
      lsf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = lsf_pkg::ST_MATCH;
        end
      end
      lsf_pkg::ST_MATCH: begin
        state_next = lsf_pkg::ST_ENCODE;
      end
      lsf_pkg::ST_ENCODE: begin
        state_next = lsf_pkg::ST_UPDATE;
      end
      lsf_pkg::ST_UPDATE: begin
        if (!out_valid || out_ready) begin
          update     = 1'b1;
          state_next = lsf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lsf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl.load = update;
    ctl.fill = fill;
    if (hit) begin
      ctl.limit = hit_idx;
    end else if (full) begin
      ctl.limit = lsf_pkg::IDX_W'(cap - lsf_pkg::CNT_W'(1));
    end else begin
      ctl.limit = lsf_pkg::IDX_W'(fill);
    end
  end

  always_comb begin
    fill_upd = fill;
    if (update && !hit && !full) begin
      fill_upd = fill + lsf_pkg::CNT_W'(1);
    end
    fill_next = fill_upd;
    if (cfg_wr_en && (fill_upd > new_cap)) begin
      fill_next = new_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= lsf_pkg::CAP_RESET;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      fill <= fill_next;
      if (update) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= msg_id[lsf_pkg::ID_BITS-1:0];
    end
    if (update) begin
      first_seen <= !hit;
    end
  end

  for (genvar i = 0; i < lsf_pkg::MAX_ENTRIES; i++) begin : g_cell
    lsf_cell u_cell (
      .clk        (clk),
      .slot_index (lsf_pkg::IDX_W'(i)),
      .key        (key),
      .prev_id    ((i == 0) ? key : ids[(i == 0) ? 0 : i - 1]),
      .ctl        (ctl),
      .id         (ids[i]),
      .match      (match_vec[i])
    );
  end

  lsf_encode u_encode (
    .clk       (clk),
    .match_vec (match_vec),
    .hit       (hit),
    .hit_idx   (hit_idx)
  );

`ifndef SYNTHESIS
  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("more than one slot matched the key");

  a_fill_within_cap: assert property (@(posedge clk) disable iff (rst)
    fill <= cap)
    else $error("fill count exceeds effective capacity");

  a_miss_grows: assert property (@(posedge clk) disable iff (rst)
    update && !hit && !full && !cfg_wr_en |=> fill == $past(fill) + lsf_pkg::CNT_W'(1))
    else $error("a miss on a store with room did not grow the fill count");
`endif

endmodule

### rtl/lsf_cell.sv
// One slot of the recency chain: holds an ID, compares it with the key and
// takes its neighbor's ID when the chain shifts. Depends on lsf_pkg.
module lsf_cell (
  input  logic                           clk,
  input  logic [lsf_pkg::IDX_W-1:0]      slot_index,
  input  logic [lsf_pkg::ID_BITS-1:0]    key,
  input  logic [lsf_pkg::ID_BITS-1:0]    prev_id,
  input  lsf_pkg::cell_ctl_t             ctl,
  output logic [lsf_pkg::ID_BITS-1:0]    id,
  output logic                           match
);

  logic valid;

  assign valid = {1'b0, slot_index} < ctl.fill;

  always_ff @(posedge clk) begin
    match <= valid && (id == key);
    if (ctl.load && (slot_index <= ctl.limit)) begin
      id <= prev_id;
    end
  end

endmodule

### rtl/lsf_encode.sv
// Registered one-hot to binary encoder for the chain's match vector.
// Depends on lsf_pkg for sizes and the constant bit masks.
module lsf_encode (
  input  logic                             clk,
  input  logic [lsf_pkg::MAX_ENTRIES-1:0]  match_vec,
  output logic                             hit,
  output logic [lsf_pkg::IDX_W-1:0]        hit_idx
);

  logic [lsf_pkg::IDX_W-1:0] idx_comb;

  always_comb begin
    for (int b = 0; b < lsf_pkg::IDX_W; b++) begin
      idx_comb[b] = |(match_vec & lsf_pkg::bit_mask(b));
    end
  end

  always_ff @(posedge clk) begin
    hit     <= |match_vec;
    hit_idx <= idx_comb;
  end

endmodule

### tb/lsf_seen_checker.sv
// Checker for the recently seen ID filter: watches both channels and the capacity port,
// keeps its own recency list to predict each first_seen flag, and compares in order.
// Depends on lsf_pkg for sizes and the capacity reset value.
module lsf_seen_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [lsf_pkg::MSG_W-1:0] msg_id,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      first_seen,
  input  logic                      cfg_wr_en,
  input  logic [lsf_pkg::CAP_W-1:0] cfg_wr_data,
  output int                        fails,
  output int                        pending,
  output int                        new_ids,
  output int                        repeats
);

  logic [lsf_pkg::ID_BITS-1:0] recent_ids [lsf_pkg::MAX_ENTRIES];
  int                          held;
  logic [lsf_pkg::CAP_W-1:0]   cap_reg;
  logic                        first_seen_due [$];

  function automatic int clamp_capacity(input logic [lsf_pkg::CAP_W-1:0] c);
    if (c == '0) return 1;
    if (int'(c) > lsf_pkg::MAX_ENTRIES) return lsf_pkg::MAX_ENTRIES;
    return int'(c);
  endfunction

  // Returns 1 when the key was not in the list; either way the key ends up most recent.
  function automatic logic lookup_and_promote(input logic [lsf_pkg::ID_BITS-1:0] key);
    int   lim;
    int   pos;
    logic fresh;
    lim = clamp_capacity(cap_reg);
    if (held > lim) held = lim;
    pos = held;
    for (int i = 0; i < held; i++) begin
      if (recent_ids[i] == key) begin
        pos = i;
        break;
      end
    end
    fresh = (pos == held);
    if (fresh) begin
      if (held >= lim) held = lim - 1;
      pos = held;
      held++;
    end
    for (int i = pos; i > 0; i--) begin
      recent_ids[i] = recent_ids[i-1];
    end
    recent_ids[0] = key;
    return fresh;
  endfunction

  always @(posedge clk) begin
    logic want;
    logic lim_dummy;
    if (rst) begin
      fails   = 0;
      new_ids = 0;
      repeats = 0;
      held    = 0;
      cap_reg = lsf_pkg::CAP_RESET;
      first_seen_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (first_seen_due.size() == 0) begin
          $error("first_seen: result with no request waiting, actual %0b", first_seen);
          fails++;
        end else begin
          want = first_seen_due.pop_front();
          if (first_seen !== want) begin
            $error("first_seen mismatch: expected %0b, actual %0b", want, first_seen);
            fails++;
          end else if (want) begin
            new_ids++;
          end else begin
            repeats++;
          end
        end
      end
      if (cfg_wr_en) begin
        cap_reg = cfg_wr_data;
        if (held > clamp_capacity(cap_reg)) held = clamp_capacity(cap_reg);
      end
      if (in_valid && in_ready) begin
        lim_dummy = lookup_and_promote(msg_id[lsf_pkg::ID_BITS-1:0]);
        first_seen_due.insert(first_seen_due.size(), lim_dummy);
      end
    end
    pending = first_seen_due.size();
  end

endmodule

### tb/tb_lru_seen_id_filter.sv
// Top of the testbench for lru_seen_id_filter: clock, reset, request and capacity stimulus,
// output stalls, watchdog and verdict. Depends on lsf_pkg, the filter and lsf_seen_checker.
module tb_lru_seen_id_filter;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 60;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [lsf_pkg::MSG_W-1:0] msg_id;
  logic                      out_valid;
  logic                      out_ready;
  logic                      first_seen;
  logic                      cfg_wr_en;
  logic [lsf_pkg::CAP_W-1:0] cfg_wr_data;

  int fails;
  int pending;
  int new_ids;
  int repeats;

  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;
  int          quiet_cycles = 0;
  int          ids_sent = 0;
  int          settings_used = 0;
  int          cur_limit = lsf_pkg::MAX_ENTRIES;
  logic [31:0] sent_ids [$];
  logic [31:0] id_pool [64];
  int          cap_plan [10] = '{200, 16, 1, 0, 2, 3, 511, 257, 64, 7};

  always #5 clk = ~clk;

  lru_seen_id_filter uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .msg_id     (msg_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .first_seen (first_seen),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  lsf_seen_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .msg_id     (msg_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .first_seen (first_seen),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fails      (fails),
    .pending    (pending),
    .new_ids    (new_ids),
    .repeats    (repeats)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output side: short random stalls, plus one long hold-off when asked for.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic offer_id(input logic [31:0] id);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    msg_id   <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ids_sent++;
    sent_ids.insert(sent_ids.size(), id);
    if (sent_ids.size() > 600) void'(sent_ids.pop_front());
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [lsf_pkg::CAP_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
    cur_limit = (v == '0) ? 1 :
                ((int'(v) > lsf_pkg::MAX_ENTRIES) ? lsf_pkg::MAX_ENTRIES : int'(v));
    for (int i = 0; i < 64; i++) id_pool[i] = $urandom;
  endtask

  // Mix of fresh IDs, repeats of the last one, a small reused pool, and IDs sent
  // about one capacity ago so that lookups land right at the eviction boundary.
  function automatic logic [31:0] pick_id();
    int sel;
    int gap;
    int pool_n;
    sel    = $urandom_range(0, 9);
    pool_n = (cur_limit + 3 < 64) ? cur_limit + 3 : 64;
    if (sel >= 8 && sent_ids.size() > cur_limit + 1) begin
      gap = cur_limit - 1 + $urandom_range(0, 2) - 1;
      if (gap < 0) gap = 0;
      return sent_ids[sent_ids.size() - 1 - gap];
    end else if (sel == 7 && sent_ids.size() > 0) begin
      return sent_ids[sent_ids.size() - 1];
    end else if (sel >= 4) begin
      return id_pool[$urandom_range(0, pool_n - 1)];
    end
    return $urandom;
  endfunction

  task automatic run_ids(input int n);
    for (int i = 0; i < n; i++) offer_id(pick_id());
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    msg_id      = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extremes and hits at the front and deeper in the list, at the reset capacity.
    offer_id(32'h0000_0000);
    offer_id(32'hFFFF_FFFF);
    offer_id(32'h0000_0000);
    offer_id(32'hFFFF_FFFF);
    offer_id(32'hAAAA_AAAA);
    offer_id(32'h5555_5555);
    offer_id(32'h5555_5555);
    offer_id(32'h0000_0000);
    // Zero capacity behaves as one, and lowering it drops the older entries.
    set_capacity(9'd0);
    offer_id(32'h0000_0005);
    offer_id(32'h0000_0005);
    offer_id(32'h0000_0006);
    offer_id(32'h0000_0005);
    set_capacity(9'd1);
    offer_id(32'h0000_0007);
    offer_id(32'h0000_0007);
    set_capacity(9'd2);
    offer_id(32'h0000_0001);
    offer_id(32'h0000_0002);
    offer_id(32'h0000_0001);
    offer_id(32'h0000_0003);
    offer_id(32'h0000_0002);
    // Capacity above the store size saturates.
    set_capacity(9'd511);
    offer_id(32'h0000_0008);
    offer_id(32'h0000_0001);

    set_capacity(9'd256);
    run_ids(140);
    hold_req = 1'b1;
    run_ids(140);
    for (int p = 0; p < 10; p++) begin
      set_capacity(lsf_pkg::CAP_W'(cap_plan[p]));
      run_ids(30);
      if (p == 4) wait_drained();
      run_ids(30);
    end

    idle_on = 1'b0;
    set_capacity(9'd256);
    run_ids(60);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Checked %0d IDs over %0d capacity settings: %0d first seen, %0d repeats.",
             ids_sent, settings_used, new_ids, repeats);
    $display("Included zero and saturated capacity, shrink on write, boundary evictions,");
    $display("and a long output stall.");
    if (fails == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lsf_pkg.sv
rtl/lsf_cell.sv
rtl/lsf_encode.sv
rtl/lru_seen_id_filter.sv
tb/lsf_seen_checker.sv
tb/tb_lru_seen_id_filter.sv
